### rtl/swu_pkg.sv
// shared types, sizes and helper functions for the stack with undo history
package swu_pkg;

	localparam int STACK_DEPTH   = 16;
	localparam int HISTORY_DEPTH = 16;
	localparam int DATA_WIDTH    = 32;

	localparam int FIELD_W = 32;
	localparam int SADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SCNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int HADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HCNT_W  = $clog2(HISTORY_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_DISPLAY = 2'd2,
		CMD_UNDO    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_OVER   = 2'd1,
		ST_UNDER  = 2'd2,
		ST_NOUNDO = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                      cmd;
		logic signed [FIELD_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] data;
		status_t                   status;
		logic                      last;
	} rsp_word_t;

	typedef struct packed {
		logic      valid;
		rsp_word_t word;
	} res_t;

	typedef struct packed {
		logic                  we;
		logic [SADDR_W-1:0]    waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [SADDR_W-1:0]    raddr;
	} stk_req_t;

	typedef struct packed {
		logic                  we;
		logic [HADDR_W-1:0]    waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [HADDR_W-1:0]    raddr;
	} hist_req_t;

	// sign extend or truncate a field value to the stored width
	function automatic logic [DATA_WIDTH-1:0] widen(input logic [FIELD_W-1:0] v);
		logic [DATA_WIDTH-1:0] r;
		int j;
		r = '0;
		for (int i = 0; i < DATA_WIDTH; i++) begin
			j = (i < FIELD_W) ? i : FIELD_W - 1;
			r[i] = v[j];
		end
		return r;
	endfunction

	// low field bits of a stored value, zero filled above a narrow store
	function automatic logic [FIELD_W-1:0] narrow(input logic [DATA_WIDTH-1:0] d);
		logic [FIELD_W-1:0] r;
		int j;
		r = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			j = (i < DATA_WIDTH) ? i : DATA_WIDTH - 1;
			r[i] = (i < DATA_WIDTH) ? d[j] : 1'b0;
		end
		return r;
	endfunction

endpackage

### rtl/swu_ram.sv
// generic single write, single read ram with registered read data
module swu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/swu_ctrl.sv
// sequencer: command decode, stack and history pointers, memory requests
module swu_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  swu_pkg::req_word_t             req_word,
	output logic                           req_stall,
	input  logic                           res_ready,
	output swu_pkg::res_t                  res,
	output swu_pkg::stk_req_t              stk_req,
	input  logic [swu_pkg::DATA_WIDTH-1:0] stk_rdata,
	output swu_pkg::hist_req_t             hist_req,
	input  logic [swu_pkg::DATA_WIDTH-1:0] hist_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_UNDO,
		S_DISP
	} state_t;

	state_t                         state_q, state_d;
	swu_pkg::cmd_t                  cmd_q;
	logic [swu_pkg::DATA_WIDTH-1:0] value_q;
	logic [swu_pkg::SCNT_W-1:0]     scnt_q, scnt_d, scnt_m1;
	logic [swu_pkg::HADDR_W-1:0]    hptr_q, hptr_d, hptr_inc, hptr_dec;
	logic [swu_pkg::HCNT_W-1:0]     hcnt_q, hcnt_d;
	logic [swu_pkg::SADDR_W-1:0]    idx_q, idx_d, top_addr;
	logic                           full, empty;

	assign full     = (scnt_q == swu_pkg::SCNT_W'(swu_pkg::STACK_DEPTH));
	assign empty    = (scnt_q == '0);
	assign scnt_m1  = scnt_q - 1'b1;
	assign top_addr = scnt_m1[swu_pkg::SADDR_W-1:0];
	assign hptr_inc = (hptr_q == swu_pkg::HADDR_W'(swu_pkg::HISTORY_DEPTH - 1)) ?
		'0 : hptr_q + 1'b1;
	assign hptr_dec = (hptr_q == '0) ?
		swu_pkg::HADDR_W'(swu_pkg::HISTORY_DEPTH - 1) : hptr_q - 1'b1;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		scnt_d   = scnt_q;
		hptr_d   = hptr_q;
		hcnt_d   = hcnt_q;
		idx_d    = idx_q;
		res      = '0;
		stk_req  = '0;
		hist_req = '0;
		res.word.status = swu_pkg::ST_OK;
		res.word.last   = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (res_ready) begin
					state_d = S_IDLE;
					unique case (cmd_q)
						swu_pkg::CMD_PUSH: begin
							res.valid = 1'b1;
							if (full) begin
								res.word.status = swu_pkg::ST_OVER;
							end else begin
								stk_req.we    = 1'b1;
								stk_req.waddr = scnt_q[swu_pkg::SADDR_W-1:0];
								stk_req.wdata = value_q;
								scnt_d        = scnt_q + 1'b1;
							end
						end
						swu_pkg::CMD_POP: begin
							if (empty) begin
								res.valid       = 1'b1;
								res.word.status = swu_pkg::ST_UNDER;
							end else begin
								stk_req.re    = 1'b1;
								stk_req.raddr = top_addr;
								scnt_d        = scnt_m1;
								state_d       = S_POP;
							end
						end
						swu_pkg::CMD_DISPLAY: begin
							if (empty) begin
								res.valid       = 1'b1;
								res.word.status = swu_pkg::ST_UNDER;
							end else begin
								stk_req.re    = 1'b1;
								stk_req.raddr = top_addr;
								idx_d         = top_addr;
								state_d       = S_DISP;
							end
						end
						swu_pkg::CMD_UNDO: begin
							if (hcnt_q == '0) begin
								res.valid       = 1'b1;
								res.word.status = swu_pkg::ST_NOUNDO;
							end else if (full) begin
								res.valid       = 1'b1;
								res.word.status = swu_pkg::ST_OVER;
							end else begin
								hist_req.re    = 1'b1;
								hist_req.raddr = hptr_dec;
								hptr_d         = hptr_dec;
								hcnt_d         = hcnt_q - 1'b1;
								state_d        = S_UNDO;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_POP: begin
				if (res_ready) begin
					res.valid      = 1'b1;
					res.word.data  = swu_pkg::narrow(stk_rdata);
					hist_req.we    = 1'b1;
					hist_req.waddr = hptr_q;
					hist_req.wdata = stk_rdata;
					hptr_d         = hptr_inc;
					if (hcnt_q != swu_pkg::HCNT_W'(swu_pkg::HISTORY_DEPTH)) begin
						hcnt_d = hcnt_q + 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_UNDO: begin
				if (res_ready) begin
					res.valid     = 1'b1;
					res.word.data = swu_pkg::narrow(hist_rdata);
					stk_req.we    = 1'b1;
					stk_req.waddr = scnt_q[swu_pkg::SADDR_W-1:0];
					stk_req.wdata = hist_rdata;
					scnt_d        = scnt_q + 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_DISP: begin
				if (res_ready) begin
					res.valid     = 1'b1;
					res.word.data = swu_pkg::narrow(stk_rdata);
					res.word.last = (idx_q == '0);
					if (idx_q == '0) begin
						state_d = S_IDLE;
					end else begin
						// fetch the next entry down while this one goes out
						stk_req.re    = 1'b1;
						stk_req.raddr = idx_q - 1'b1;
						idx_d         = idx_q - 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scnt_q  <= '0;
			hptr_q  <= '0;
			hcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			scnt_q  <= scnt_d;
			hptr_q  <= hptr_d;
			hcnt_q  <= hcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (state_q == S_IDLE && req_valid) begin
			cmd_q   <= req_word.cmd;
			value_q <= swu_pkg::widen(req_word.value);
		end
	end

endmodule

### rtl/stack_with_undo.sv
// top level: bounded stack with undo history, sequencer, two rams, output register
//
//  channel  direction  handshake             word
//  req      in         req_valid/req_stall   cmd, value
//  rsp      out        rsp_valid/rsp_stall   data, status, last
//
// a command is taken only while the sequencer is idle, then runs alone
// push and every error case end in exec; pop and undo add a registered ram read state
// display goes top down, one entry a cycle off the stack ram read port unless stalled
// a stalled result holds the output register and the sequencer waits on it
// reset clears state, counters, history pointer and rsp_valid; the rams keep no reset
module stack_with_undo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  swu_pkg::req_word_t req_word,
	output logic               req_stall,
	output logic               rsp_valid,
	output swu_pkg::rsp_word_t rsp_word,
	input  logic               rsp_stall
);

	swu_pkg::res_t                  res;
	swu_pkg::stk_req_t              stk_req;
	swu_pkg::hist_req_t             hist_req;
	logic [swu_pkg::DATA_WIDTH-1:0] stk_rdata;
	logic [swu_pkg::DATA_WIDTH-1:0] hist_rdata;
	logic                           res_ready;
	logic                           rsp_valid_q;
	swu_pkg::rsp_word_t             rsp_word_q;

	// output register frees when empty or when its word is taken this cycle
	assign res_ready = !rsp_valid_q || !rsp_stall;

	swu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_word   (req_word),
		.req_stall  (req_stall),
		.res_ready  (res_ready),
		.res        (res),
		.stk_req    (stk_req),
		.stk_rdata  (stk_rdata),
		.hist_req   (hist_req),
		.hist_rdata (hist_rdata)
	);

	// data stack entries, bottom at address zero
	swu_ram #(
		.WIDTH (swu_pkg::DATA_WIDTH),
		.DEPTH (swu_pkg::STACK_DEPTH)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_req.we),
		.waddr (stk_req.waddr),
		.wdata (stk_req.wdata),
		.re    (stk_req.re),
		.raddr (stk_req.raddr),
		.rdata (stk_rdata)
	);

	// ring of popped values for undo
	swu_ram #(
		.WIDTH (swu_pkg::DATA_WIDTH),
		.DEPTH (swu_pkg::HISTORY_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_req.we),
		.waddr (hist_req.waddr),
		.wdata (hist_req.wdata),
		.re    (hist_req.re),
		.raddr (hist_req.raddr),
		.rdata (hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res.valid;
		end
	end

	// payload only loads with a new word, so a stalled word stays put
	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			rsp_word_q <= res.word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

endmodule

### rtl/swu_chk.sv
// port level checker for the stack with undo history, bound to the top level
module swu_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input swu_pkg::rsp_word_t rsp_word,
	input logic               rsp_stall
);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("stalled result word changed");

	// a taken command blocks the request side on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while a command is running");

	// error results carry zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status != swu_pkg::ST_OK |-> rsp_word.data == '0)
		else $error("error result with non-zero data");

	// only display entries are not final, and they are always ok
	a_nonlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.last |-> rsp_word.status == swu_pkg::ST_OK)
		else $error("non-final result with error status");

endmodule

bind stack_with_undo swu_chk u_swu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_word  (rsp_word),
	.rsp_stall (rsp_stall)
);
